// ===== rtl/kcle_pkg.sv =====
// Package for the keyed circular list engine: kind and status codes,
// cell control struct and fixed field widths. No dependencies.
`default_nettype none
package kcle_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 5;
    localparam int DATA_W       = 32;

    localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PREPEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UPDATE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SHOW    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic rot;   // rotate the ring one place toward cell 0
        logic ins;   // open a gap at pos and load the new entry
        logic del;   // close the gap at pos
        logic upd;   // overwrite the value at pos
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/kcle_cell.sv =====
// One list cell: holds the entry at list position IDX and moves it to or
// from its neighbors on rotate, insert and delete. Depends on kcle_pkg.
`default_nettype none
module kcle_cell #(
    parameter int N   = kcle_pkg::DEF_CAPACITY,
    parameter int IDX = 0
) (
    input  wire                         clk,
    input  wire kcle_pkg::cell_ctrl_t   ctrl,
    input  wire [$clog2(N)-1:0]         pos,
    input  wire [kcle_pkg::DATA_W-1:0]  left_key,
    input  wire [kcle_pkg::DATA_W-1:0]  left_val,
    input  wire [kcle_pkg::DATA_W-1:0]  right_key,
    input  wire [kcle_pkg::DATA_W-1:0]  right_val,
    input  wire [kcle_pkg::DATA_W-1:0]  new_key,
    input  wire [kcle_pkg::DATA_W-1:0]  new_val,
    output logic [kcle_pkg::DATA_W-1:0] key,
    output logic [kcle_pkg::DATA_W-1:0] val
);
    import kcle_pkg::*;

    localparam int IW = $clog2(N);
    localparam logic [IW-1:0] MY_POS = IW'(IDX);

    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] val_reg, val_next;

    always_comb
    begin
        key_next = key_reg;
        val_next = val_reg;
        if (ctrl.rot)
        begin
            key_next = right_key;
            val_next = right_val;
        end
        else if (ctrl.ins)
        begin
            if (MY_POS == pos)
            begin
                key_next = new_key;
                val_next = new_val;
            end
            else if (MY_POS > pos)
            begin
                key_next = left_key;
                val_next = left_val;
            end
        end
        else if (ctrl.del)
        begin
            if (MY_POS >= pos && IDX != N - 1)
            begin
                key_next = right_key;
                val_next = right_val;
            end
        end
        else if (ctrl.upd && MY_POS == pos)
        begin
            val_next = new_val;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    assign key = key_reg;
    assign val = val_reg;

endmodule
`default_nettype wire

// ===== rtl/keyed_circular_list_engine.sv =====
// Top level of the keyed circular list engine: control sequencer and a ring
// of kcle_cell instances. Depends on kcle_pkg and kcle_cell.
//
// The list is kept in order in a ring of CAPACITY cells, head in cell 0.
// Every item (except the unused kinds 6 and 7, which are dropped) makes one
// full turn of the ring, comparing the entry passing cell 0 with the keys,
// then applies the change and posts the status in an apply step that waits
// for a free output register. Show on a non-empty list has no apply step:
// it sends one item per entry as the ring turns, and stalls the turn while
// the output is held. A finished result waits in the output register while
// the next item is taken.
`default_nettype none
module keyed_circular_list_engine #(
    parameter int CAPACITY = kcle_pkg::DEF_CAPACITY
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [95:0] s_tdata,   // key [31:0], new_key [63:32], new_value [95:64]
    input  wire  [2:0]  s_tuser,   // kind [2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // out_key [31:0], out_value [63:32], entry_count [68:64], zero
    output logic [2:0]  m_tuser,   // status [2:0]
    output logic        m_tlast    // is_last
);
    import kcle_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_S = IW'(CAPACITY - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

    state_t            state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] nk_reg, nk_next;
    logic [DATA_W-1:0] nv_reg, nv_next;
    logic [IW-1:0]     step_reg, step_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     fpos_reg, fpos_next;
    logic              dup_reg, dup_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_key_reg, out_key_next;
    logic [DATA_W-1:0]   out_val_reg, out_val_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;

    cell_ctrl_t        ctrl;
    logic [IW-1:0]     pos;
    logic [DATA_W-1:0] cell_key [CAPACITY];
    logic [DATA_W-1:0] cell_val [CAPACITY];

    logic out_free, in_acc, live, advance, is_full;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            kcle_cell #(.N(CAPACITY), .IDX(g)) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .pos      (pos),
                .left_key (cell_key[(g == 0) ? 0 : g - 1]),
                .left_val (cell_val[(g == 0) ? 0 : g - 1]),
                .right_key(cell_key[(g + 1) % CAPACITY]),
                .right_val(cell_val[(g + 1) % CAPACITY]),
                .new_key  (nk_reg),
                .new_val  (nv_reg),
                .key      (cell_key[g]),
                .val      (cell_val[g])
            );
        end
    endgenerate

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign live     = (CW'(step_reg) < count_reg);
    assign is_full  = (count_reg == CAP_C);
    // a show holds the ring while an entry waits for a free output register
    assign advance  = (kind_reg != KIND_SHOW) || !live || out_free;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        nk_next         = nk_reg;
        nv_next         = nv_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        fpos_next       = fpos_reg;
        dup_next        = dup_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_val_next    = out_val_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        ctrl            = '0;
        pos             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && s_tuser <= KIND_SHOW)
                begin
                    kind_next  = s_tuser;
                    key_next   = s_tdata[31:0];
                    nk_next    = s_tdata[63:32];
                    nv_next    = s_tdata[95:64];
                    step_next  = '0;
                    found_next = 1'b0;
                    dup_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    ctrl.rot = 1'b1;
                    if (live)
                    begin
                        if (cell_key[0] == key_reg && !found_reg)
                        begin
                            found_next = 1'b1;
                            fpos_next  = step_reg;
                        end
                        if (cell_key[0] == nk_reg)
                            dup_next = 1'b1;
                        if (kind_reg == KIND_SHOW)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_OK;
                            out_key_next    = cell_key[0];
                            out_val_next    = cell_val[0];
                            out_count_next  = COUNT_W'(count_reg);
                            out_last_next   = (CW'(step_reg) + CW'(1) == count_reg);
                        end
                    end
                    step_next = step_reg + IW'(1);
                    if (step_reg == LAST_S)
                    begin
                        if (kind_reg == KIND_SHOW && count_reg != '0)
                            state_next = S_IDLE;
                        else
                            state_next = S_APPLY;
                    end
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    out_status_next = ST_OK;
                    case (kind_reg)
                        KIND_APPEND, KIND_PREPEND:
                        begin
                            if (dup_reg)
                                out_status_next = ST_EXISTS;
                            else if (is_full)
                                out_status_next = ST_FULL;
                            else
                            begin
                                ctrl.ins   = 1'b1;
                                pos        = (kind_reg == KIND_APPEND) ?
                                             count_reg[IW-1:0] : '0;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (count_reg == '0)
                                out_status_next = ST_EMPTY;
                            else if (!found_reg)
                                out_status_next = ST_MISSING;
                            else if (dup_reg)
                                out_status_next = ST_EXISTS;
                            else if (is_full)
                                out_status_next = ST_FULL;
                            else
                            begin
                                ctrl.ins   = 1'b1;
                                pos        = fpos_reg + IW'(1);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_DELETE, KIND_UPDATE:
                        begin
                            if (count_reg == '0)
                                out_status_next = ST_EMPTY;
                            else if (!found_reg)
                                out_status_next = ST_MISSING;
                            else if (kind_reg == KIND_DELETE)
                            begin
                                ctrl.del   = 1'b1;
                                pos        = fpos_reg;
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                ctrl.upd = 1'b1;
                                pos      = fpos_reg;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_EMPTY;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_key_next   = '0;
                    out_val_next   = '0;
                    out_count_next = COUNT_W'(count_next);
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            dup_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            dup_reg       <= dup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        nk_reg         <= nk_next;
        nv_reg         <= nv_next;
        fpos_reg       <= fpos_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_val_reg    <= out_val_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_val_reg, out_key_reg};

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count beyond capacity");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser <= KIND_SHOW) |=> (state_reg == S_SCAN))
        else $error("valid kind did not start a ring turn");

    a_apply_post: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && out_free) |=> (m_tvalid && m_tlast
                                                && state_reg == S_IDLE))
        else $error("status item not posted after apply");

    a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && kind_reg != KIND_SHOW && m_tvalid && !m_tready)
        |=> m_tvalid)
        else $error("held item lost during search");

endmodule
`default_nettype wire
